### sv/pfa_pkg.sv
`timescale 1ns / 1ps

package pfa_pkg;

  localparam int NUM_FRAMES       = 32768;
  localparam int FIRST_FREE_FRAME = 513;
  localparam int COUNT_BITS       = 16;
  localparam int FRAME_W          = 15;
  localparam int MODE_W           = 2;
  localparam int STATUS_W         = 2;
  localparam int LINK_W           = FRAME_W + 1;

  typedef logic [FRAME_W-1:0]    frame_t;
  typedef logic [COUNT_BITS-1:0] count_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_ALLOC = 2'd0,
    MODE_FREE  = 2'd1,
    MODE_INC   = 2'd2,
    MODE_DEC   = 2'd3
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK      = 2'd0,
    STAT_NO_MEM  = 2'd1,
    STAT_REFUSED = 2'd2,
    STAT_RSVD    = 2'd3
  } status_t;

  // One entry of the link memory: end-of-list flag over the next frame.
  typedef struct packed {
    logic   last;
    frame_t next;
  } link_t;

  localparam logic [FRAME_W:0] NUM_FRAMES_V = (FRAME_W + 1)'(NUM_FRAMES);
  localparam frame_t           LAST_FRAME   = FRAME_W'(NUM_FRAMES - 1);
  localparam frame_t           FIRST_FREE   = FRAME_W'(FIRST_FREE_FRAME);
  localparam logic             START_EMPTY  = (FIRST_FREE_FRAME >= NUM_FRAMES);
  localparam count_t           COUNT_MAX    = {COUNT_BITS{1'b1}};

endpackage

### sv/pfa_if.sv
`timescale 1ns / 1ps

interface pfa_req_if;
  import pfa_pkg::*;

  logic   valid;
  logic   ready;
  logic [MODE_W-1:0] mode;
  frame_t frame;

  modport source (output valid, output mode, output frame, input ready);
  modport sink   (input valid, input mode, input frame, output ready);
endinterface

interface pfa_rsp_if;
  import pfa_pkg::*;

  logic   valid;
  logic   ready;
  logic [STATUS_W-1:0] status;
  frame_t granted_frame;
  logic   freed;
  logic [15:0] new_count;

  modport source (output valid, output status, output granted_frame, output freed,
                  output new_count, input ready);
  modport sink   (input valid, input status, input granted_frame, input freed,
                  input new_count, output ready);
endinterface

### sv/pfa_ram.sv
`timescale 1ns / 1ps

module pfa_ram #(
  parameter int DEPTH = 32768,
  parameter int WIDTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### sv/page_frame_allocator.sv
`timescale 1ns / 1ps

// Page frame allocator with per-frame reference counts.
// in_req carries one request word (mode, frame): allocate, free, increment or
// decrement. out_rsp returns exactly one response word per request: status,
// granted frame, freed flag and the frame's count after the request.
// Both channels use valid/ready; a word moves when both are high.
// Free frames form a LIFO list threaded through a link memory; counts sit in
// a second memory. Both have a registered read port.
// A request's memories are read at the edge that accepts it, and the
// read-modify-write and the response are registered from the execute state
// once the output register is free; the block takes no new request before
// then, and the response is driven onto out_rsp from that register.
// After reset the block sweeps both memories, one frame per cycle, over all
// NUM_FRAMES frames (32768): counts go to zero and each frame links to the
// next. in_req.ready stays low during the sweep.
// While a response waits on out_rsp, the block still accepts one request and
// holds its result in the read stage until the output register frees up.
module page_frame_allocator (
  input  logic clk,
  input  logic rst_n,
  pfa_req_if.sink   in_req,
  pfa_rsp_if.source out_rsp
);
  import pfa_pkg::*;

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_EXEC  = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  frame_t clr_idx_r, clr_idx_nxt;
  frame_t head_r, head_nxt;
  logic   empty_r, empty_nxt;

  mode_t  mode_r;
  frame_t frame_r;

  logic    out_valid_r;
  status_t status_r;
  frame_t  granted_r;
  logic    freed_r;
  count_t  count_r;

  // memory ports
  logic   link_we, cnt_we, mem_re;
  frame_t link_waddr, cnt_waddr, mem_raddr;
  link_t  link_wdata, link_rd, exec_link;
  count_t cnt_wdata, cnt_rd, exec_cnt;
  logic [LINK_W-1:0] link_rd_raw;

  logic   cnt_we_q;
  frame_t cnt_waddr_q;
  count_t cnt_wdata_q;

  logic   accept;
  logic   load_out;
  logic   in_range;

  status_t res_status;
  frame_t  res_granted;
  logic    res_freed;
  count_t  res_count;
  logic    push;

  assign accept    = (state_r == ST_IDLE) && in_req.valid;
  assign in_req.ready = (state_r == ST_IDLE);
  assign mem_re    = accept;
  assign mem_raddr = (mode_t'(in_req.mode) == MODE_ALLOC) ? head_r : in_req.frame;
  assign load_out  = (state_r == ST_EXEC) && (!out_valid_r || out_rsp.ready);
  assign in_range  = ({1'b0, frame_r} < NUM_FRAMES_V);

  assign link_rd  = link_t'(link_rd_raw);
  assign exec_link = link_rd;
  assign exec_cnt  = cnt_rd;

  pfa_ram #(.DEPTH(NUM_FRAMES), .WIDTH(LINK_W)) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata (LINK_W'(link_wdata)),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (link_rd_raw)
  );

  pfa_ram #(.DEPTH(NUM_FRAMES), .WIDTH(COUNT_BITS)) u_count_ram (
    .clk   (clk),
    .we    (cnt_we_q),
    .waddr (cnt_waddr_q),
    .wdata (cnt_wdata_q),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (cnt_rd)
  );

  // Work out the result and the write-back of the request in the read stage.
  always_comb begin
    res_status  = STAT_OK;
    res_granted = '0;
    res_freed   = 1'b0;
    res_count   = '0;
    push        = 1'b0;
    cnt_we      = 1'b0;
    cnt_waddr   = frame_r;
    cnt_wdata   = '0;
    head_nxt    = head_r;
    empty_nxt   = empty_r;

    if (mode_r == MODE_ALLOC) begin
      if (empty_r) begin
        res_status = STAT_NO_MEM;
      end else begin
        res_granted = head_r;
        res_count   = exec_cnt;
        if (exec_link.last) begin
          empty_nxt = 1'b1;
        end else begin
          head_nxt = exec_link.next;
        end
      end
    end else if (!in_range) begin
      res_status = STAT_REFUSED;
    end else begin
      case (mode_r)
        MODE_FREE: begin
          push      = 1'b1;
          res_count = exec_cnt;
        end
        MODE_INC: begin
          if (exec_cnt == COUNT_MAX) begin
            res_status = STAT_REFUSED;
            res_count  = exec_cnt;
          end else begin
            cnt_we    = 1'b1;
            cnt_wdata = exec_cnt + 1'b1;
            res_count = cnt_wdata;
          end
        end
        MODE_DEC: begin
          if (exec_cnt == '0) begin
            res_status = STAT_REFUSED;
          end else begin
            cnt_we    = 1'b1;
            cnt_wdata = exec_cnt - 1'b1;
            res_count = cnt_wdata;
            push      = (cnt_wdata == '0);
          end
        end
        default: begin
          res_status = STAT_REFUSED;
        end
      endcase
    end

    if (push) begin
      res_freed = 1'b1;
      head_nxt  = frame_r;
      empty_nxt = 1'b0;
    end
  end

  // Link and count write ports: sweep after reset, else the link is written back on push and the count on inc or dec.
  always_comb begin
    link_we         = 1'b0;
    link_waddr      = frame_r;
    link_wdata.last = empty_r;
    link_wdata.next = head_r;
    if (state_r == ST_CLEAR) begin
      link_we         = 1'b1;
      link_waddr      = clr_idx_r;
      link_wdata.last = (clr_idx_r == LAST_FRAME);
      link_wdata.next = clr_idx_r + 1'b1;
    end else if (load_out && push) begin
      link_we = 1'b1;
    end
  end

  always_comb begin
    cnt_we_q    = load_out && cnt_we;
    cnt_waddr_q = cnt_waddr;
    cnt_wdata_q = cnt_wdata;
    if (state_r == ST_CLEAR) begin
      cnt_we_q    = 1'b1;
      cnt_waddr_q = clr_idx_r;
      cnt_wdata_q = '0;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    clr_idx_nxt = clr_idx_r;
    case (state_r)
      ST_CLEAR: begin
        clr_idx_nxt = clr_idx_r + 1'b1;
        if (clr_idx_r == LAST_FRAME) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (load_out) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_idx_r   <= '0;
      head_r      <= FIRST_FREE;
      empty_r     <= START_EMPTY;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      clr_idx_r <= clr_idx_nxt;
      if (load_out) begin
        head_r      <= head_nxt;
        empty_r     <= empty_nxt;
        out_valid_r <= 1'b1;
      end else if (out_rsp.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Request hold and response payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r  <= mode_t'(in_req.mode);
      frame_r <= in_req.frame;
    end
    if (load_out) begin
      status_r  <= res_status;
      granted_r <= res_granted;
      freed_r   <= res_freed;
      count_r   <= res_count;
    end
  end

  assign out_rsp.valid         = out_valid_r;
  assign out_rsp.status        = status_r;
  assign out_rsp.granted_frame = granted_r;
  assign out_rsp.freed         = freed_r;
  assign out_rsp.new_count     = 16'(count_r);

endmodule

### tb/page_frame_allocator_tb.sv
`timescale 1ns / 1ps

module page_frame_allocator_tb;
  import pfa_pkg::*;

  typedef struct packed {
    status_t     status;
    frame_t      granted;
    logic        freed;
    logic [15:0] count;
  } rsp_word_t;

  logic clk = 1'b0;
  logic rst_n;

  pfa_req_if req_if ();
  pfa_rsp_if rsp_if ();

  page_frame_allocator i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_req (req_if),
    .out_rsp(rsp_if)
  );

  // Shadow copy of the free list and the reference counts
  frame_t shadow_next [NUM_FRAMES];
  bit     shadow_last [NUM_FRAMES];
  count_t shadow_refs [NUM_FRAMES];
  frame_t shadow_head;
  bit     shadow_empty;

  rsp_word_t   expected_rsps[$];
  rsp_word_t   last_rsp;
  int unsigned send_idle_pct;
  int unsigned stall_pct;
  int unsigned words_sent;
  int unsigned words_checked;
  int unsigned n_no_mem;
  int unsigned n_refused;
  int unsigned n_freed;
  int unsigned n_errors;

  always #4 clk = ~clk;

  function automatic void reset_shadow();
    for (int i = 0; i < NUM_FRAMES; i++) begin
      shadow_refs[i] = '0;
      shadow_next[i] = frame_t'(i + 1);
      shadow_last[i] = (i == NUM_FRAMES - 1);
    end
    shadow_empty = START_EMPTY;
    shadow_head  = START_EMPTY ? frame_t'(0) : FIRST_FREE;
  endfunction

  function automatic void push_free(frame_t f);
    shadow_next[f] = shadow_head;
    shadow_last[f] = shadow_empty;
    shadow_head    = f;
    shadow_empty   = 1'b0;
  endfunction

  function automatic rsp_word_t predict_rsp(mode_t m, frame_t f);
    rsp_word_t r;
    frame_t    g;
    r        = '0;
    r.status = STAT_OK;
    if (m == MODE_ALLOC) begin
      if (shadow_empty) begin
        r.status = STAT_NO_MEM;
      end else begin
        g = shadow_head;
        if (shadow_last[g]) shadow_empty = 1'b1;
        else shadow_head = shadow_next[g];
        r.granted = g;
        r.count   = 16'(shadow_refs[g]);
      end
    end else if (int'(f) >= NUM_FRAMES) begin
      r.status = STAT_REFUSED;
    end else begin
      case (m)
        MODE_FREE: begin
          // push without looking at the count, even if already on the list
          push_free(f);
          r.freed = 1'b1;
        end
        MODE_INC: begin
          if (shadow_refs[f] == COUNT_MAX) r.status = STAT_REFUSED;
          else shadow_refs[f] = shadow_refs[f] + 1'b1;
        end
        MODE_DEC: begin
          if (shadow_refs[f] == '0) begin
            r.status = STAT_REFUSED;
          end else begin
            shadow_refs[f] = shadow_refs[f] - 1'b1;
            if (shadow_refs[f] == '0) begin
              push_free(f);
              r.freed = 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
      r.count = 16'(shadow_refs[f]);
    end
    return r;
  endfunction

  // Hold valid for one word until it is taken, then record what must come back.
  task automatic send_word(mode_t m, frame_t f);
    while ($urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.mode  <= m;
    req_if.frame <= f;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    last_rsp = predict_rsp(m, f);
    expected_rsps.push_back(last_rsp);
    words_sent++;
  endtask

  task automatic drain_responses();
    req_if.valid <= 1'b0;
    do @(posedge clk); while (expected_rsps.size() != 0);
  endtask

  task automatic test_directed();
    send_word(MODE_ALLOC, '1);
    send_word(MODE_ALLOC, '0);
    send_word(MODE_INC, FIRST_FREE);
    send_word(MODE_INC, FIRST_FREE);
    send_word(MODE_DEC, FIRST_FREE);
    send_word(MODE_DEC, FIRST_FREE);    // reaches zero: back on the list
    send_word(MODE_ALLOC, '0);
    send_word(MODE_DEC, '0);            // underflow
    send_word(MODE_INC, '0);
    send_word(MODE_FREE, '0);           // free while still referenced
    send_word(MODE_ALLOC, '1);
    send_word(MODE_FREE, frame_t'(1));
    send_word(MODE_ALLOC, '0);
    send_word(MODE_INC, frame_t'(512));
    send_word(MODE_DEC, frame_t'(512));
    send_word(MODE_ALLOC, '0);
  endtask

  task automatic test_double_free();
    send_word(MODE_FREE, frame_t'(100));
    send_word(MODE_ALLOC, '0);
    send_word(MODE_ALLOC, '0);
    send_word(MODE_INC, '1);
    send_word(MODE_FREE, '1);
    send_word(MODE_FREE, '1);           // already free: the list now loops on itself
    repeat (3) send_word(MODE_ALLOC, '0);
    send_word(MODE_DEC, '1);
    send_word(MODE_DEC, '1);
    send_word(MODE_FREE, frame_t'(100));
  endtask

  task automatic random_traffic(int unsigned n_words);
    int unsigned start;
    int unsigned pick;
    int unsigned n_inc;
    frame_t      f;
    start = words_sent;
    while (words_sent - start < n_words) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        // allocate, take references, drop them all and sometimes one more
        send_word(MODE_ALLOC, frame_t'($urandom));
        if (last_rsp.status == STAT_OK) begin
          f     = last_rsp.granted;
          n_inc = $urandom_range(3, 1);
          repeat (n_inc) send_word(MODE_INC, f);
          while (shadow_refs[f] != '0) send_word(MODE_DEC, f);
          if ($urandom_range(3) == 0) send_word(MODE_DEC, f);
        end
      end else if (pick < 70) begin
        send_word(MODE_FREE, frame_t'($urandom));
      end else if (pick < 85) begin
        f = frame_t'($urandom);
        send_word(MODE_INC, f);
        send_word(MODE_DEC, f);
      end else begin
        send_word(mode_t'($urandom_range(3)), frame_t'($urandom));
      end
    end
  endtask

  task automatic test_random_phases();
    send_idle_pct = 0;
    stall_pct     = 0;
    random_traffic(160);
    send_idle_pct = 86;
    random_traffic(80);
    drain_responses();
    random_traffic(80);
    send_idle_pct = 0;
    stall_pct     = 86;
    random_traffic(160);
    send_idle_pct = 17;
    stall_pct     = 17;
    random_traffic(160);
  endtask

  always @(posedge clk) begin : rsp_check
    rsp_word_t want;
    if (!rst_n) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (expected_rsps.size() == 0) begin
          n_errors++;
          if (n_errors <= 10)
            $display("unexpected response word: status %0d frame %0d freed %0d count %0d",
                     rsp_if.status, rsp_if.granted_frame, rsp_if.freed, rsp_if.new_count);
        end else begin
          want = expected_rsps.pop_front();
          words_checked++;
          if (want.status == STAT_NO_MEM) n_no_mem++;
          if (want.status == STAT_REFUSED) n_refused++;
          if (want.freed) n_freed++;
          if (rsp_if.status !== want.status || rsp_if.granted_frame !== want.granted ||
              rsp_if.freed !== want.freed || rsp_if.new_count !== want.count) begin
            n_errors++;
            if (n_errors <= 10)
              $display("response %0d mismatch: exp %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                       words_checked, want.status, want.granted, want.freed, want.count,
                       rsp_if.status, rsp_if.granted_frame, rsp_if.freed, rsp_if.new_count);
          end
        end
      end
      rsp_if.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  initial begin
    #10_000_000;
    $display("timeout: handshakes stopped");
    $display("page_frame_allocator test failed");
    $finish;
  end

  initial begin
    rst_n         = 1'b0;
    req_if.valid  = 1'b0;
    req_if.mode   = MODE_ALLOC;
    req_if.frame  = '0;
    send_idle_pct = 0;
    stall_pct     = 0;
    reset_shadow();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_double_free();
    test_random_phases();

    drain_responses();
    repeat (8) @(posedge clk);
    $display("run: %0d request words, %0d responses checked, free list looped by a double free",
             words_sent, words_checked);
    $display("     %0d out of frames, %0d refused, %0d frees, under sender gaps and stalls",
             n_no_mem, n_refused, n_freed);
    if (n_errors == 0) begin
      $display("page_frame_allocator test passed");
    end else begin
      $display("%0d mismatches", n_errors);
      $display("page_frame_allocator test failed");
    end
    $finish;
  end

endmodule
